// ===== hdl/pit_pkg.sv =====
// Shared types and constants for the point-in-tetrahedron test.
package pit_pkg;

    localparam int PNT_W       = 16;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int SETTLE_W    = 2;

    // Cycles the input is held off after a vertex write while derived values settle.
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_A = 2'd0,
        CFG_VERTEX_B = 2'd1,
        CFG_VERTEX_C = 2'd2,
        CFG_VERTEX_D = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PNT_W-1:0] point_z;
        logic [PNT_W-1:0] point_y;
        logic [PNT_W-1:0] point_x;
    } t_in_item;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } t_out_item;

    // Load enables for the three register stages of a face sign unit.
    typedef struct packed {
        logic mul_en;
        logic add_en;
        logic sgn_en;
    } t_adv;

    // Sign of an exact dot product.
    typedef struct packed {
        logic neg;
        logic zero;
    } t_sign;

endpackage

// ===== hdl/pit_face.sv =====
// Pipelined sign of an exact dot product between a face normal and an offset vector.
module pit_face import pit_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                                 i_clk,
    input  t_adv                                 i_adv,
    input  logic [2:0][2*COORD_BITS+1:0]         i_norm,
    input  logic [2:0][COORD_BITS:0]             i_q,
    output t_sign                                o_sign
);

    localparam int QW  = COORD_BITS + 1;
    localparam int NW  = 2 * COORD_BITS + 2;
    localparam int H   = COORD_BITS + 1;
    localparam int HW  = NW - H;
    localparam int LPW = H + 1 + QW;
    localparam int HPW = HW + QW;
    localparam int LSW = LPW + 2;
    localparam int HSW = HPW + 2;
    localparam int TW  = HSW + H + 1;

    logic signed [LPW-1:0] n_lo [3];
    logic signed [HPW-1:0] n_hi [3];
    logic signed [LPW-1:0] r_lo [3];
    logic signed [HPW-1:0] r_hi [3];
    logic signed [LSW-1:0] n_slo, r_slo;
    logic signed [HSW-1:0] n_shi, r_shi;
    logic signed [TW-1:0]  n_tot;
    t_sign                 n_sign, r_sign;

    // The normal is split into an unsigned low half and a signed high half so each
    // product stays near 17 by 17 bits at the default width.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lo[k] = LPW'($signed({1'b0, i_norm[k][H-1:0]})) * LPW'($signed(i_q[k]));
            n_hi[k] = HPW'($signed(i_norm[k][NW-1:H])) * HPW'($signed(i_q[k]));
        end
        n_slo       = LSW'(r_lo[0]) + LSW'(r_lo[1]) + LSW'(r_lo[2]);
        n_shi       = HSW'(r_hi[0]) + HSW'(r_hi[1]) + HSW'(r_hi[2]);
        n_tot       = (TW'(r_shi) <<< H) + TW'(r_slo);
        n_sign.neg  = n_tot[TW-1];
        n_sign.zero = (n_tot == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.mul_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_adv.add_en) begin
            r_slo <= n_slo;
            r_shi <= n_shi;
        end
        if (i_adv.sgn_en) begin
            r_sign <= n_sign;
        end
    end

    assign o_sign = r_sign;

endmodule

// ===== hdl/pit_geom.sv =====
// Face normals and volume sign derived from the configured vertices.
module pit_geom import pit_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic [3:0][CFG_DATA_W-1:0]            i_vtx,
    output logic [3:0][2:0][2*COORD_BITS+1:0]     o_norm,
    output logic [2:0][COORD_BITS-1:0]            o_coord_a,
    output logic [2:0][COORD_BITS-1:0]            o_coord_b,
    output t_sign                                 o_vol
);

    localparam int CB = COORD_BITS;
    localparam int QW = CB + 1;
    localparam int NW = 2 * CB + 2;
    localparam int XW = 3 * CB + CFG_DATA_W;

    // Edge vectors: b-a, c-a, d-a, c-b, d-b.
    localparam int E_DA = 2;
    localparam int EP [5] = '{1, 2, 3, 2, 3};
    localparam int EM [5] = '{0, 0, 0, 1, 1};
    // Edge pairs whose cross product gives the normal of the face opposite each vertex.
    localparam int FU [4] = '{3, 1, 0, 0};
    localparam int FW [4] = '{4, 2, 2, 1};
    localparam int K1 [3] = '{1, 2, 0};
    localparam int K2 [3] = '{2, 0, 1};

    localparam t_adv ADV_ON = '{mul_en: 1'b1, add_en: 1'b1, sgn_en: 1'b1};

    logic [XW-1:0]                  ext;
    logic [3:0][2:0][CB-1:0]        crd;
    logic [4:0][2:0][QW-1:0]        n_e, r_e;
    logic [3:0][2:0][1:0][NW-1:0]   n_pr, r_pr;
    logic [3:0][2:0][NW-1:0]        n_norm, r_norm;
    logic [2:0][QW-1:0]             r_da2, r_da3;

    always_comb begin
        ext = '0;
        for (int v = 0; v < 4; v++) begin
            ext = {{(3*CB){1'b0}}, i_vtx[v]};
            for (int k = 0; k < 3; k++) begin
                crd[v][k] = ext[k*CB +: CB];
            end
        end
        for (int e = 0; e < 5; e++) begin
            for (int k = 0; k < 3; k++) begin
                n_e[e][k] = QW'($signed({1'b0, crd[EP[e]][k]})
                              - $signed({1'b0, crd[EM[e]][k]}));
            end
        end
        for (int f = 0; f < 4; f++) begin
            for (int k = 0; k < 3; k++) begin
                n_pr[f][k][0] = NW'($signed(r_e[FU[f]][K1[k]]))
                              * NW'($signed(r_e[FW[f]][K2[k]]));
                n_pr[f][k][1] = NW'($signed(r_e[FU[f]][K2[k]]))
                              * NW'($signed(r_e[FW[f]][K1[k]]));
                n_norm[f][k]  = r_pr[f][k][0] - r_pr[f][k][1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_pr   <= n_pr;
        r_norm <= n_norm;
        r_da2  <= r_e[E_DA];
        r_da3  <= r_da2;
    end

    // Six times the signed volume: normal of face a,b,c against d-a.
    pit_face #(
        .COORD_BITS (COORD_BITS)
    ) u_vol (
        .i_clk  (i_clk),
        .i_adv  (ADV_ON),
        .i_norm (r_norm[3]),
        .i_q    (r_da3),
        .o_sign (o_vol)
    );

    assign o_norm    = r_norm;
    assign o_coord_a = crd[0];
    assign o_coord_b = crd[1];

endmodule

// ===== hdl/point_in_tetrahedron_test.sv =====
// Top level of the point-in-tetrahedron test: config registers and the point pipeline.
// An accepted request passes the point, offset, face sign and compare stages to o_out_valid.
// Throughput: one request per cycle, set by the fully pipelined face sign units, unless stalled.
// After reset and after each vertex write the input is stalled while the normals settle.
// Reset (synchronous, active low) clears all vertices to zero and empties the pipeline.
// With all-zero vertices every result reports degenerate until real vertices are written.
module point_in_tetrahedron_test import pit_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int QW = CB + 1;
    localparam int NW = 2 * CB + 2;

    // Vertex registers and the settle counter that holds off requests after
    // reset or a write, until the derived geometry reflects the vertices.
    logic [3:0][CFG_DATA_W-1:0] r_vtx;
    logic [SETTLE_W-1:0]        r_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx    <= '0;
            r_settle <= SETTLE_CYCLES;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_VERTEX_A: r_vtx[0] <= i_cfg_data;
                    CFG_VERTEX_B: r_vtx[1] <= i_cfg_data;
                    CFG_VERTEX_C: r_vtx[2] <= i_cfg_data;
                    CFG_VERTEX_D: r_vtx[3] <= i_cfg_data;
                endcase
                r_settle <= SETTLE_CYCLES;
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 1'b1;
            end
        end
    end

    // The normals and the volume sign depend only on the vertices, so they are
    // computed once in a free-running side pipeline rather than per request.
    logic [3:0][2:0][NW-1:0] w_norm;
    logic [2:0][CB-1:0]      w_coord_a;
    logic [2:0][CB-1:0]      w_coord_b;
    t_sign                   w_vol;

    pit_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk     (i_clk),
        .i_vtx     (r_vtx),
        .o_norm    (w_norm),
        .o_coord_a (w_coord_a),
        .o_coord_b (w_coord_b),
        .o_vol     (w_vol)
    );

    // Stage flow control. Stage k takes new data whenever it is empty or its
    // successor is taking its contents, so bubbles collapse under a stall.
    logic [6:1] r_v;
    logic [6:1] rdy;
    logic       n_v1;

    always_comb begin
        rdy[6] = !r_v[6] || !i_out_stall;
        for (int k = 5; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign n_v1       = i_in_valid && (r_settle == '0);
    assign o_in_stall = !rdy[1] || (r_settle != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) begin
                r_v[1] <= n_v1;
            end
            for (int k = 2; k <= 6; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1 captures the point, masked to the coordinate width.
    // Stage 2 forms the point's offsets from vertex a and vertex b.
    logic [2:0][CB-1:0] n_p1, r_p1;
    logic [2:0][QW-1:0] n_qa, r_qa;
    logic [2:0][QW-1:0] n_qb, r_qb;

    always_comb begin
        n_p1[0] = CB'({{CB{1'b0}}, i_in_data.point_x});
        n_p1[1] = CB'({{CB{1'b0}}, i_in_data.point_y});
        n_p1[2] = CB'({{CB{1'b0}}, i_in_data.point_z});
        for (int k = 0; k < 3; k++) begin
            n_qa[k] = QW'($signed({1'b0, r_p1[k]}) - $signed({1'b0, w_coord_a[k]}));
            n_qb[k] = QW'($signed({1'b0, r_p1[k]}) - $signed({1'b0, w_coord_b[k]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_p1 <= n_p1;
        end
        if (rdy[2]) begin
            r_qa <= n_qa;
            r_qb <= n_qb;
        end
    end

    // Stages 3 to 5: one sign unit per face. The face opposite vertex a is
    // anchored at b; the other three faces are anchored at a.
    t_adv  w_adv;
    t_sign w_sign [4];

    assign w_adv = '{mul_en: rdy[3], add_en: rdy[4], sgn_en: rdy[5]};

    for (genvar f = 0; f < 4; f++) begin : g_face
        pit_face #(
            .COORD_BITS (COORD_BITS)
        ) u_face (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_norm (w_norm[f]),
            .i_q    ((f == 0) ? r_qb : r_qa),
            .o_sign (w_sign[f])
        );
    end

    // Stage 6: compare each face sign with that of its opposite vertex. Those
    // signs are all +/- the volume sign: faces opposite a and c see the negated
    // volume, faces opposite b and d see it unchanged. A zero dot product means
    // the point lies on that face's plane, which passes.
    logic      vol_pos;
    logic [3:0] pass;
    t_out_item n_out, r_out;

    always_comb begin
        vol_pos          = !w_vol.neg && !w_vol.zero;
        pass[0]          = w_sign[0].zero || (w_sign[0].neg == vol_pos);
        pass[1]          = w_sign[1].zero || (w_sign[1].neg == w_vol.neg);
        pass[2]          = w_sign[2].zero || (w_sign[2].neg == vol_pos);
        pass[3]          = w_sign[3].zero || (w_sign[3].neg == w_vol.neg);
        n_out.degenerate = w_vol.zero;
        n_out.inside_res = !w_vol.zero && (&pass);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v[6];
    assign o_out_data  = r_out;

    // A vertex write must hold off new requests in the following cycle.
    a_cfg_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("request window open right after a vertex write");

    // A degenerate tetrahedron never reports a point as inside.
    a_deg_not_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.inside_res && o_out_data.degenerate))
        else $error("inside and degenerate both set");

    // A blocked middle stage keeps its request.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && !rdy[4]) |=> r_v[3])
        else $error("blocked stage lost its request");

    // A new result can only come from a request that sat in stage five.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v[5]))
        else $error("result appeared without a request behind it");

endmodule
